// ===== rtl/core/bcld_pkg.sv =====
`default_nettype none
package bcld_pkg;
  localparam int ENTRIES = 32;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [7:0] NODEV = 8'd255;

  localparam logic [2:0] REQ_GET   = 3'd0;
  localparam logic [2:0] REQ_PUT   = 3'd1;
  localparam logic [2:0] REQ_DIRTY = 3'd2;
  localparam logic [2:0] REQ_SYNC  = 3'd3;
  localparam logic [2:0] REQ_PURGE = 3'd4;

  localparam logic [2:0] KIND_DONE    = 3'd0;
  localparam logic [2:0] KIND_WB      = 3'd1;
  localparam logic [2:0] KIND_READ    = 3'd2;
  localparam logic [2:0] KIND_NOFREE  = 3'd3;
  localparam logic [2:0] KIND_NOTHELD = 3'd4;

  localparam logic [1:0] MODE_ALWAYS = 2'd0;
  localparam logic [1:0] MODE_SANE   = 2'd1;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_HSTEP, OP_HHIT, OP_VINIT, OP_VSTEP, OP_VWB, OP_VFILL,
    OP_NOFREE, OP_PLACE0, OP_PLACE1, OP_PUT, OP_SSTEP, OP_SEND, OP_PCLR, OP_ISTEP
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       hmatch;
    logic       free;
    logic       dirty;
    logic       pmatch;
    logic       i_last;
    logic       i_end;
  } status_t;
endpackage
`default_nettype wire

// ===== rtl/core/bcld_datapath.sv =====
`default_nettype none
module bcld_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bcld_pkg::cmd_t  cmd,
  output bcld_pkg::status_t    status,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_wdata,
  input  wire logic [2:0]      req_type,
  input  wire logic [7:0]      req_device,
  input  wire logic [31:0]     req_block,
  input  wire logic [4:0]      req_entry,
  input  wire logic            important,
  output logic                 result_strobe,
  output logic [2:0]           kind,
  output logic [4:0]           result_entry,
  output logic [7:0]           cmd_device,
  output logic [31:0]          cmd_block,
  output logic                 hit,
  output logic                 last
);
  import bcld_pkg::*;

  logic [7:0]       tag_dev [ENTRIES];
  logic [31:0]      tag_blk [ENTRIES];
  logic [7:0]       use_cnt [ENTRIES];
  logic             dirty   [ENTRIES];
  logic [IDX_W-1:0] older   [ENTRIES];
  logic [IDX_W-1:0] newer   [ENTRIES];
  logic [IDX_W-1:0] oldest;
  logic [1:0]       robust_mode;

  logic [2:0]       r_type;
  logic [7:0]       r_dev;
  logic [31:0]      r_blk;
  logic [4:0]       r_ent;
  logic             r_imp;
  logic [IDX_W-1:0] p;
  logic [IDX_W-1:0] e;
  logic [IDX_W-1:0] pend;
  logic             pend_ok;
  logic [CNT_W-1:0] i;

  logic [IDX_W-1:0] ii;
  logic [IDX_W-1:0] ent_ix;
  logic             ent_ok;
  logic [7:0]       cnt_dec;
  logic             put_wb;
  logic [IDX_W-1:0] o2;

  assign ii      = i[IDX_W-1:0];
  assign ent_ix  = r_ent[IDX_W-1:0];
  assign ent_ok  = ({1'b0, r_ent} < 6'(ENTRIES)) && (use_cnt[ent_ix] != 8'd0);
  assign cnt_dec = use_cnt[ent_ix] - 8'd1;
  assign put_wb  = (cnt_dec == 8'd0) && dirty[ent_ix] &&
                   ((robust_mode == MODE_ALWAYS) || ((robust_mode == MODE_SANE) && r_imp));
  assign o2      = older[oldest];

  always_comb begin
    status.req_type = r_type;
    status.hmatch   = (tag_dev[p] == r_dev) && (tag_blk[p] == r_blk);
    status.free     = (use_cnt[p] == 8'd0);
    status.dirty    = dirty[p];
    status.pmatch   = (tag_dev[ii] == r_dev);
    status.i_last   = (i == CNT_W'(ENTRIES - 1));
    status.i_end    = (i == CNT_W'(ENTRIES));
  end

  always_ff @(posedge clk) begin
    result_strobe <= 1'b0;
    if (rst) begin
      robust_mode <= MODE_SANE;
      oldest <= '0;
      for (int k = 0; k < ENTRIES; k++) begin
        tag_dev[k] <= NODEV;
        tag_blk[k] <= '0;
        use_cnt[k] <= '0;
        dirty[k]   <= 1'b0;
        older[k]   <= IDX_W'((k + ENTRIES - 1) % ENTRIES);
        newer[k]   <= IDX_W'((k + 1) % ENTRIES);
      end
    end else begin
      if (cfg_we) robust_mode <= cfg_wdata;
      unique case (cmd.op)
        OP_LATCH: begin
          r_type <= req_type; r_dev <= req_device; r_blk <= req_block;
          r_ent <= req_entry; r_imp <= important;
          p <= older[oldest]; i <= '0; pend_ok <= 1'b0;
        end
        OP_HSTEP: begin
          p <= older[p]; i <= i + CNT_W'(1);
        end
        OP_HHIT: begin
          if (use_cnt[p] != 8'd255) use_cnt[p] <= use_cnt[p] + 8'd1;
          e <= p;
          result_strobe <= 1'b1; kind <= KIND_DONE; result_entry <= 5'(p);
          cmd_device <= NODEV; cmd_block <= '0; hit <= 1'b1; last <= 1'b1;
        end
        OP_VINIT: begin
          p <= oldest; i <= '0;
        end
        OP_VSTEP: begin
          p <= newer[p]; i <= i + CNT_W'(1);
        end
        OP_VWB: begin
          dirty[p] <= 1'b0;
          result_strobe <= 1'b1; kind <= KIND_WB; result_entry <= 5'(p);
          cmd_device <= tag_dev[p]; cmd_block <= tag_blk[p]; hit <= 1'b0; last <= 1'b0;
        end
        OP_VFILL: begin
          tag_dev[p] <= r_dev; tag_blk[p] <= r_blk; use_cnt[p] <= 8'd1;
          dirty[p] <= 1'b0; e <= p;
          result_strobe <= 1'b1; kind <= KIND_READ; result_entry <= 5'(p);
          cmd_device <= r_dev; cmd_block <= r_blk; hit <= 1'b0; last <= 1'b1;
        end
        OP_NOFREE: begin
          result_strobe <= 1'b1; kind <= KIND_NOFREE; result_entry <= '0;
          cmd_device <= NODEV; cmd_block <= '0; hit <= 1'b0; last <= 1'b1;
        end
        OP_PLACE0: begin
          if (e == oldest) oldest <= newer[e];
          newer[older[e]] <= newer[e];
          older[newer[e]] <= older[e];
        end
        OP_PLACE1: begin
          older[e] <= o2;
          newer[e] <= oldest;
          older[oldest] <= e;
          newer[o2] <= e;
          if (r_type == REQ_PURGE) oldest <= e;
          i <= i + CNT_W'(1);
        end
        OP_PUT: begin
          result_strobe <= 1'b1; hit <= 1'b0; last <= 1'b1;
          result_entry <= r_ent; cmd_device <= NODEV; cmd_block <= '0;
          if (!ent_ok) begin
            kind <= KIND_NOTHELD;
          end else if (r_type == REQ_DIRTY) begin
            dirty[ent_ix] <= 1'b1; kind <= KIND_DONE;
          end else begin
            use_cnt[ent_ix] <= cnt_dec;
            if (put_wb) begin
              dirty[ent_ix] <= 1'b0; kind <= KIND_WB;
              cmd_device <= tag_dev[ent_ix]; cmd_block <= tag_blk[ent_ix];
            end else begin
              kind <= KIND_DONE;
            end
          end
        end
        OP_SSTEP: begin
          if (status.pmatch && dirty[ii]) begin
            dirty[ii] <= 1'b0;
            if (pend_ok) begin
              result_strobe <= 1'b1; kind <= KIND_WB; result_entry <= 5'(pend);
              cmd_device <= tag_dev[pend]; cmd_block <= tag_blk[pend];
              hit <= 1'b0; last <= 1'b0;
            end
            pend <= ii; pend_ok <= 1'b1;
          end
          i <= i + CNT_W'(1);
        end
        OP_SEND: begin
          result_strobe <= 1'b1; hit <= 1'b0; last <= 1'b1;
          if (pend_ok) begin
            kind <= KIND_WB; result_entry <= 5'(pend);
            cmd_device <= tag_dev[pend]; cmd_block <= tag_blk[pend];
          end else begin
            kind <= KIND_DONE; result_entry <= '0;
            cmd_device <= NODEV; cmd_block <= '0;
          end
        end
        OP_PCLR: begin
          tag_dev[ii] <= NODEV; tag_blk[ii] <= '0; use_cnt[ii] <= '0;
          dirty[ii] <= 1'b0; e <= ii;
        end
        OP_ISTEP: begin
          i <= i + CNT_W'(1);
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/bcld_controller.sv =====
`default_nettype none
module bcld_controller (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire bcld_pkg::status_t status,
  output bcld_pkg::cmd_t         cmd
);
  import bcld_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DISP   = 13'b0000000000010,
    S_HSCAN  = 13'b0000000000100,
    S_VINIT  = 13'b0000000001000,
    S_VSCAN  = 13'b0000000010000,
    S_VFILL  = 13'b0000000100000,
    S_NOFREE = 13'b0000001000000,
    S_PLACE0 = 13'b0000010000000,
    S_PLACE1 = 13'b0000100000000,
    S_PUT    = 13'b0001000000000,
    S_SSCAN  = 13'b0010000000000,
    S_PSCAN  = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE: if (start) begin
        cmd.op = OP_LATCH; state_next = S_DISP;
      end
      S_DISP: begin
        case (status.req_type)
          REQ_GET: state_next = S_HSCAN;
          REQ_PUT, REQ_DIRTY: state_next = S_PUT;
          REQ_SYNC: state_next = S_SSCAN;
          REQ_PURGE: state_next = S_PSCAN;
          default: state_next = S_DONE;
        endcase
      end
      S_HSCAN: begin
        if (status.hmatch) begin
          cmd.op = OP_HHIT; state_next = S_PLACE0;
        end else begin
          cmd.op = OP_HSTEP;
          if (status.i_last) state_next = S_VINIT;
        end
      end
      S_VINIT: begin
        cmd.op = OP_VINIT; state_next = S_VSCAN;
      end
      S_VSCAN: begin
        if (status.free) begin
          if (status.dirty) begin
            cmd.op = OP_VWB; state_next = S_VFILL;
          end else begin
            cmd.op = OP_VFILL; state_next = S_PLACE0;
          end
        end else begin
          cmd.op = OP_VSTEP;
          if (status.i_last) state_next = S_NOFREE;
        end
      end
      S_VFILL: begin
        cmd.op = OP_VFILL; state_next = S_PLACE0;
      end
      S_NOFREE: begin
        cmd.op = OP_NOFREE; state_next = S_IDLE;
      end
      S_PLACE0: begin
        cmd.op = OP_PLACE0; state_next = S_PLACE1;
      end
      S_PLACE1: begin
        cmd.op = OP_PLACE1;
        state_next = (status.req_type == REQ_PURGE) ? S_PSCAN : S_IDLE;
      end
      S_PUT: begin
        cmd.op = OP_PUT; state_next = S_IDLE;
      end
      S_SSCAN: begin
        if (status.i_end) begin
          cmd.op = OP_SEND; state_next = S_IDLE;
        end else begin
          cmd.op = OP_SSTEP;
        end
      end
      S_PSCAN: begin
        if (status.i_end) begin
          state_next = S_DONE;
        end else if (status.pmatch) begin
          cmd.op = OP_PCLR; state_next = S_PLACE0;
        end else begin
          cmd.op = OP_ISTEP;
        end
      end
      S_DONE: begin
        cmd.op = OP_SEND; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule
`default_nettype wire

// ===== rtl/core/block_cache_lru_directory_top.sv =====
`default_nettype none
// Put and mark dirty are latched, dispatched and answered from the put state; get time is
// set by the walk of the LRU chain, one entry per cycle for lookup and again for the victim.
// Sync and purge sweep the entries in index order, one per cycle save where purge clears a match.
// Throughput: one transaction at a time; busy stays high until the directory update ends.
// Reset: synchronous rst restores empty tags, clean zero counts and the index-ordered LRU ring.
// Results are strobed for one cycle each; the receiver cannot stall.
module block_cache_lru_directory_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic [2:0]  req_type,
  input  wire logic [7:0]  req_device,
  input  wire logic [31:0] req_block,
  input  wire logic [4:0]  req_entry,
  input  wire logic        important,
  output logic             result_strobe,
  output logic [2:0]       kind,
  output logic [4:0]       result_entry,
  output logic [7:0]       cmd_device,
  output logic [31:0]      cmd_block,
  output logic             hit,
  output logic             last
);
  import bcld_pkg::*;

  // The controller sequences each transaction; the datapath owns the directory arrays.
  cmd_t    cmd;
  status_t status;

  bcld_controller u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .status(status), .cmd(cmd)
  );

  bcld_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_type(req_type), .req_device(req_device), .req_block(req_block),
    .req_entry(req_entry), .important(important),
    .result_strobe(result_strobe), .kind(kind), .result_entry(result_entry),
    .cmd_device(cmd_device), .cmd_block(cmd_block), .hit(hit), .last(last)
  );

  // A result is always produced by work started in an earlier busy cycle.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy)) else $error("result without a transaction");

  // An accepted transaction makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transaction not started");

  // Only a get hit reports hit, and it is always a done result.
  a_hit_done: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && hit) |-> (kind == KIND_DONE && last)) else $error("bad hit result");

  // A real device only appears on transfer commands.
  a_cmd_dev: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && kind != KIND_WB && kind != KIND_READ) |-> (cmd_device == NODEV))
    else $error("device on a non-command result");
endmodule
`default_nettype wire
